// ----- rtl/rcsg_pkg.sv -----
// Shared types and constants for the resource context size governor.
// Depends on nothing; the top level, controller and datapath import it.
`timescale 1ns / 1ps

package rcsg_pkg;

   localparam int                 DIV_STEPS     = 16;
   localparam int                 DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam logic [16:0]        ONE_Q16       = 17'd65536;
   localparam logic [16:0]        HALF_Q16      = 17'd32768;
   localparam logic [15:0]        CPU_LIMIT_Q16 = 16'd19661;
   localparam logic [15:0]        SCORE_MAX     = 16'hFFFF;
   localparam logic [15:0]        SIZE_FLOOR    = 16'd128;
   localparam int                 POW_COUNT     = 5;
   localparam logic [15:0]        POW_SIZES [POW_COUNT] =
      '{16'd128, 16'd256, 16'd512, 16'd1024, 16'd2048};

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_RAM_WEIGHT     = 3'd0,
      CSR_CPU_WEIGHT     = 3'd1,
      CSR_BATTERY_WEIGHT = 3'd2,
      CSR_LOW_RAM        = 3'd3,
      CSR_HIGH_RAM       = 3'd4,
      CSR_MIN_CONTEXT    = 3'd5,
      CSR_MAX_CONTEXT    = 3'd6,
      CSR_EMA_FACTOR     = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_RAM,
      ST_MUL_CPU,
      ST_MUL_BAT,
      ST_SUM,
      ST_SCORE,
      ST_MUL_RANGE,
      ST_PICK,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_AVG,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_RAM,
      MUL_CPU,
      MUL_BAT,
      MUL_RANGE,
      MUL_NEW,
      MUL_OLD
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        capture;
      logic        div_step;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        score_load;
      logic        raw_load;
      logic        result_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [47:0] free_memory;
      logic [47:0] total_memory;
      logic [15:0] cpu_load;
      logic        battery_valid;
      logic [15:0] battery_fraction;
      logic        charging;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] raw_context;
      logic [11:0] smoothed_context;
      logic [15:0] headroom_score;
   } rsp_payload_type;

   // Largest power of two from the size table that is not above target and
   // not above limit; fallback when none qualifies.
   function automatic logic [15:0] snap_size(input logic [16:0] target,
                                             input logic [15:0] limit,
                                             input logic [15:0] fallback);
      logic [15:0] best;
      best = fallback;
      for (int i = 0; i < POW_COUNT; i++) begin
         if (({1'b0, POW_SIZES[i]} <= target) && (POW_SIZES[i] <= limit)) begin
            best = POW_SIZES[i];
         end
      end
      return best;
   endfunction

endpackage

// ----- rtl/rcsg_if.sv -----
// Valid/ready channel interfaces for the request and result streams.
// Stand-alone; widths follow the fixed field widths of the block.
`timescale 1ns / 1ps

interface rcsg_req_if;
   logic        valid;
   logic        ready;
   logic [47:0] free_memory;
   logic [47:0] total_memory;
   logic [15:0] cpu_load;
   logic        battery_valid;
   logic [15:0] battery_fraction;
   logic        charging;

   modport source (
      output valid, free_memory, total_memory, cpu_load, battery_valid,
             battery_fraction, charging,
      input  ready
   );
   modport sink (
      input  valid, free_memory, total_memory, cpu_load, battery_valid,
             battery_fraction, charging,
      output ready
   );
endinterface

interface rcsg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_context;
   logic [11:0] smoothed_context;
   logic [15:0] headroom_score;

   modport source (
      output valid, raw_context, smoothed_context, headroom_score,
      input  ready
   );
   modport sink (
      input  valid, raw_context, smoothed_context, headroom_score,
      output ready
   );
endinterface

// ----- rtl/resource_context_size_governor_unit.sv -----
// Top level of the resource context size governor: controller, datapath
// and port adaption. Depends on rcsg_pkg, rcsg_if, rcsg_ctrl, rcsg_dpath.
`timescale 1ns / 1ps

// Each request is one device-state sample; each yields exactly one result
// holding the raw context size, the smoothed power-of-two size (128 to 2048)
// and the clamped Q0.16 resource score. One request is worked at a time:
// a new request is taken only once the previous one has reached its result
// register. The bit-serial divider forms the free/total RAM ratio; the
// remaining steps use the single shared 17x17 multiplier (three score
// products, the interpolation product and the two moving-average products)
// and its accumulator. The result sits in an output register, so the block
// goes on to the next request while a result waits; it only pauses at the
// final step if the previous result still has not been taken. Configuration
// writes take effect at once and belong only to idle periods.
module resource_context_size_governor_unit import rcsg_pkg::*; #(
   parameter logic [15:0] START_CONTEXT = 16'd512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [16:0]       csr_wdata,
   rcsg_req_if.sink          req_if,
   rcsg_rsp_if.source        rsp_if
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   // Gather the request fields for the datapath
   assign req_data.free_memory      = req_if.free_memory;
   assign req_data.total_memory     = req_if.total_memory;
   assign req_data.cpu_load         = req_if.cpu_load;
   assign req_data.battery_valid    = req_if.battery_valid;
   assign req_data.battery_fraction = req_if.battery_fraction;
   assign req_data.charging         = req_if.charging;

   // Sequence the request through divide, multiply and snap steps
   rcsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold configuration, compute and register the result
   rcsg_dpath #(
      .START_CONTEXT (START_CONTEXT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.raw_context      = rsp_data.raw_context;
   assign rsp_if.smoothed_context = rsp_data.smoothed_context;
   assign rsp_if.headroom_score   = rsp_data.headroom_score;

   // An accepted request makes the block busy in the next cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while previous request still in work");

   // A shown smoothed size is always a power of two of at least 128
   a_smooth_pow2 : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ($onehot(rsp_if.smoothed_context) &&
                        (rsp_if.smoothed_context >= 12'd128)))
      else $error("smoothed size is not a snapped power of two");

   // Never overwrite a result that is still waiting to be taken
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> !(rsp_if.valid && !rsp_if.ready))
      else $error("pending result overwritten");

endmodule

// ----- rtl/rcsg_ctrl.sv -----
// Sequencing state machine of the governor: walks one request through the
// divider and shared multiplier steps. Depends on rcsg_pkg.
`timescale 1ns / 1ps

module rcsg_ctrl import rcsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   div_last;

   assign div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            div_cnt_in = '0;
            if (req_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_MUL_RAM;
            end
         end
         ST_MUL_RAM:   state_in = ST_MUL_CPU;
         ST_MUL_CPU:   state_in = ST_MUL_BAT;
         ST_MUL_BAT:   state_in = ST_SUM;
         ST_SUM:       state_in = ST_SCORE;
         ST_SCORE:     state_in = ST_MUL_RANGE;
         ST_MUL_RANGE: state_in = ST_PICK;
         ST_PICK:      state_in = ST_MUL_NEW;
         ST_MUL_NEW:   state_in = ST_MUL_OLD;
         ST_MUL_OLD:   state_in = ST_AVG;
         ST_AVG:       state_in = ST_DONE;
         ST_DONE: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.mul_sel     = MUL_RAM;
      cmd.acc_op      = ACC_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DIV:       cmd.div_step = 1'b1;
         ST_MUL_RAM:   cmd.mul_sel  = MUL_RAM;
         ST_MUL_CPU: begin
            cmd.mul_sel = MUL_CPU;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_MUL_BAT: begin
            cmd.mul_sel = MUL_BAT;
            cmd.acc_op  = ACC_ADD;
         end
         ST_SUM:       cmd.acc_op     = ACC_ADD;
         ST_SCORE:     cmd.score_load = 1'b1;
         ST_MUL_RANGE: cmd.mul_sel    = MUL_RANGE;
         ST_PICK:      cmd.raw_load   = 1'b1;
         ST_MUL_NEW:   cmd.mul_sel    = MUL_NEW;
         ST_MUL_OLD: begin
            cmd.mul_sel = MUL_OLD;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_AVG:       cmd.acc_op     = ACC_ADD;
         ST_DONE:      cmd.result_load = !status.out_busy;
         default:      cmd = '0;
      endcase
   end

endmodule

// ----- rtl/rcsg_dpath.sv -----
// Datapath of the governor: configuration registers, bit-serial ratio
// divider, shared 17x17 multiplier with accumulator, size snap and output
// register. Depends on rcsg_pkg.
`timescale 1ns / 1ps

module rcsg_dpath import rcsg_pkg::*; #(
   parameter logic [15:0] START_CONTEXT = 16'd512
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [16:0]     csr_wdata,
   input  req_payload_type req_data,
   input  cmd_type         cmd,
   output status_type      status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   // Configuration
   logic [16:0] ram_weight_ff, cpu_weight_ff, battery_weight_ff, ema_factor_ff;
   logic [15:0] low_ram_ff, high_ram_ff, min_context_ff, max_context_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_weight_ff     <= '0;
         cpu_weight_ff     <= '0;
         battery_weight_ff <= '0;
         low_ram_ff        <= '0;
         high_ram_ff       <= 16'hFFFF;
         min_context_ff    <= 16'd128;
         max_context_ff    <= 16'd2048;
         ema_factor_ff     <= HALF_Q16;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAM_WEIGHT:     ram_weight_ff     <= csr_wdata;
            CSR_CPU_WEIGHT:     cpu_weight_ff     <= csr_wdata;
            CSR_BATTERY_WEIGHT: battery_weight_ff <= csr_wdata;
            CSR_LOW_RAM:        low_ram_ff        <= csr_wdata[15:0];
            CSR_HIGH_RAM:       high_ram_ff       <= csr_wdata[15:0];
            CSR_MIN_CONTEXT:    min_context_ff    <= csr_wdata[15:0];
            CSR_MAX_CONTEXT:    max_context_ff    <= csr_wdata[15:0];
            CSR_EMA_FACTOR:     ema_factor_ff     <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Captured sample and divider
   logic [47:0] total_ff, rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] cpu_ff;
   logic [16:0] batt_ff;
   logic        zero_ff, sat_ff;
   logic [48:0] rem_shift;
   logic        rem_ge;
   logic [16:0] ratio;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, total_ff});
   assign rem_in    = rem_ge ? 48'(rem_shift - {1'b0, total_ff}) : rem_shift[47:0];
   assign quo_in    = {quo_ff[14:0], rem_ge};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         total_ff <= req_data.total_memory;
         rem_ff   <= req_data.free_memory;
         quo_ff   <= '0;
         cpu_ff   <= req_data.cpu_load;
         batt_ff  <= (req_data.battery_valid && !req_data.charging) ?
                     {1'b0, req_data.battery_fraction} : ONE_Q16;
         zero_ff  <= (req_data.total_memory == '0);
         sat_ff   <= (req_data.free_memory >= req_data.total_memory);
      end else if (cmd.div_step) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end
   end

   assign ratio = zero_ff ? HALF_Q16 : (sat_ff ? ONE_Q16 : {1'b0, quo_ff});

   // Shared multiplier and accumulator
   logic [16:0] ema_sat, ema_rest, mul_a, mul_b;
   logic [33:0] prod_ff, prod_in;
   logic [35:0] acc_ff;
   logic [15:0] score_ff, raw_ff, range_w, interp_w, raw_in;
   logic [16:0] target_w;
   logic [15:0] cur_ff;

   assign ema_sat  = (ema_factor_ff > ONE_Q16) ? ONE_Q16 : ema_factor_ff;
   assign ema_rest = ONE_Q16 - ema_sat;
   assign range_w  = (max_context_ff > min_context_ff) ?
                     (max_context_ff - min_context_ff) : '0;

   always_comb begin
      case (cmd.mul_sel)
         MUL_RAM: begin
            mul_a = ram_weight_ff;
            mul_b = ratio;
         end
         MUL_CPU: begin
            mul_a = cpu_weight_ff;
            mul_b = ONE_Q16 - {1'b0, cpu_ff};
         end
         MUL_BAT: begin
            mul_a = battery_weight_ff;
            mul_b = batt_ff;
         end
         MUL_RANGE: begin
            mul_a = {1'b0, score_ff};
            mul_b = {1'b0, range_w};
         end
         MUL_NEW: begin
            mul_a = ema_sat;
            mul_b = {1'b0, raw_ff};
         end
         MUL_OLD: begin
            mul_a = ema_rest;
            mul_b = {1'b0, cur_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= {2'b00, prod_ff};
         ACC_ADD:  acc_ff <= acc_ff + {2'b00, prod_ff};
         default:  acc_ff <= acc_ff;
      endcase
   end

   // Score and raw size
   assign interp_w = prod_ff[31:16];
   assign target_w = {1'b0, min_context_ff} + {1'b0, interp_w};

   always_comb begin
      if (ratio < {1'b0, low_ram_ff}) begin
         raw_in = min_context_ff;
      end else if ((ratio > {1'b0, high_ram_ff}) && (cpu_ff < CPU_LIMIT_Q16)) begin
         raw_in = max_context_ff;
      end else begin
         raw_in = snap_size(target_w, max_context_ff, min_context_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.score_load) begin
         score_ff <= (acc_ff[35:16] > {4'b0000, SCORE_MAX}) ? SCORE_MAX : acc_ff[31:16];
      end
      if (cmd.raw_load) begin
         raw_ff <= raw_in;
      end
   end

   // Smoothed size, kept state and output register
   logic [15:0] smooth_w;
   logic        rsp_valid_ff, rsp_valid_in;

   assign smooth_w = snap_size({1'b0, acc_ff[31:16]}, 16'hFFFF, SIZE_FLOOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= START_CONTEXT;
      end else if (cmd.result_load) begin
         cur_ff <= smooth_w;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_data.raw_context      <= raw_ff;
         rsp_data.smoothed_context <= smooth_w[11:0];
         rsp_data.headroom_score   <= score_ff;
      end
   end

   assign rsp_valid_in = cmd.result_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

endmodule
